// ===== hw/rtl/gpsm_pkg.sv =====
package gpsm_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 9;

  localparam int unsigned HALF_W  = 10;
  localparam int unsigned GAP_W   = 12;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TICK_W  = 12;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned BIT_W   = 3;
  localparam int unsigned CFG_W   = 12;

  localparam logic [HALF_W-1:0] HALF_RST  = 10'd5;
  localparam logic [GAP_W-1:0]  GAP_RST   = 12'd16;
  localparam logic [BYTE_W-1:0] ADDR_RST  = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_RST   = 8'h42;
  localparam logic [BYTE_W-1:0] ANALOG_ID = 8'h73;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HALF = 2'd0,
    REG_GAP  = 2'd1,
    REG_ADDR = 2'd2,
    REG_CMD  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic start_req;
    logic din;
  } in_t;

  typedef struct packed {
    logic              select_n;
    logic              clk_out;
    logic              dout;
    logic              byte_done;
    logic [CNT_W-1:0]  byte_index;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_done;
    logic              analog_red;
    logic              busy_res;
  } out_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic [GAP_W-1:0]  byte_gap_ticks;
    logic [BYTE_W-1:0] poll_address;
    logic [BYTE_W-1:0] poll_command;
  } cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [BIT_W-1:0]  bit_count;
    logic [CNT_W-1:0]  byte_count;
    logic [TICK_W-1:0] tick_count;
    logic [BYTE_W-1:0] tx_shift;
    logic [BYTE_W-1:0] rx_shift;
    logic [BYTE_W-1:0] id_byte;
  } state_t;

endpackage

// ===== hw/rtl/gpsm_step.sv =====
module gpsm_step #(
  parameter int unsigned FRAME_BYTES = gpsm_pkg::FRAME_BYTES_DEF
) (
  input  gpsm_pkg::state_t st,
  input  gpsm_pkg::cfg_t   cfg,
  input  gpsm_pkg::in_t    item,
  output gpsm_pkg::state_t st_nxt,
  output gpsm_pkg::out_t   res
);
  import gpsm_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES);

  logic [HALF_W-1:0] half;
  logic [TICK_W:0]   tick_inc;
  logic              half_end;
  logic              gap_end;
  logic              adv;
  logic [CNT_W-1:0]  byte_inc;
  logic              done;
  logic [CNT_W-1:0]  idx;
  logic [BYTE_W-1:0] rxb;
  logic              frame_flag;
  logic              red_flag;

  assign half     = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;
  assign tick_inc = {1'b0, st.tick_count} + (TICK_W+1)'(1);
  assign half_end = tick_inc >= (TICK_W+1)'(half);
  assign gap_end  = tick_inc >= (TICK_W+1)'(cfg.byte_gap_ticks);
  assign byte_inc = st.byte_count + CNT_W'(1);

  always_comb begin
    st_nxt     = st;
    adv        = 1'b0;
    done       = 1'b0;
    idx        = '0;
    rxb        = '0;
    frame_flag = 1'b0;
    red_flag   = 1'b0;

    unique case (st.phase)
      PH_IDLE: begin
        if (item.start_req) begin
          st_nxt.phase      = PH_HIGH;
          st_nxt.bit_count  = '0;
          st_nxt.byte_count = '0;
          st_nxt.tick_count = '0;
          st_nxt.tx_shift   = cfg.poll_address;
          st_nxt.rx_shift   = '0;
          st_nxt.id_byte    = '0;
        end
      end
      PH_HIGH: begin
        if (half_end) begin
          st_nxt.phase      = PH_LOW;
          st_nxt.tick_count = '0;
        end else begin
          st_nxt.tick_count = tick_inc[TICK_W-1:0];
        end
      end
      PH_LOW: begin
        if (half_end) begin
          st_nxt.rx_shift   = {item.din, st.rx_shift[BYTE_W-1:1]};
          st_nxt.tick_count = '0;
          if (st.bit_count == '1) begin
            done             = 1'b1;
            idx              = st.byte_count;
            rxb              = st_nxt.rx_shift;
            st_nxt.bit_count = '0;
            if (st.byte_count == CNT_W'(1)) st_nxt.id_byte = st_nxt.rx_shift;
            if (cfg.byte_gap_ticks != '0) st_nxt.phase = PH_GAP;
            else adv = 1'b1;
          end else begin
            st_nxt.bit_count = st.bit_count + BIT_W'(1);
            st_nxt.tx_shift  = {1'b0, st.tx_shift[BYTE_W-1:1]};
            st_nxt.phase     = PH_HIGH;
          end
        end else begin
          st_nxt.tick_count = tick_inc[TICK_W-1:0];
        end
      end
      PH_GAP: begin
        if (gap_end) adv = 1'b1;
        else st_nxt.tick_count = tick_inc[TICK_W-1:0];
      end
      default: st_nxt.phase = PH_IDLE;
    endcase

    // move on to the next byte, or close the frame
    if (adv) begin
      st_nxt.tick_count = '0;
      st_nxt.bit_count  = '0;
      st_nxt.rx_shift   = '0;
      if (byte_inc >= LAST_CNT) begin
        st_nxt.phase      = PH_IDLE;
        st_nxt.byte_count = '0;
        frame_flag        = 1'b1;
        red_flag          = (st_nxt.id_byte == ANALOG_ID);
      end else begin
        st_nxt.byte_count = byte_inc;
        st_nxt.tx_shift   = (byte_inc == CNT_W'(1)) ? cfg.poll_command : '0;
        st_nxt.phase      = PH_HIGH;
      end
    end
  end

  assign res.select_n   = (st_nxt.phase == PH_IDLE);
  assign res.clk_out    = (st_nxt.phase != PH_LOW);
  assign res.dout       = ((st_nxt.phase == PH_HIGH) || (st_nxt.phase == PH_LOW))
                          ? st_nxt.tx_shift[0] : 1'b0;
  assign res.byte_done  = done;
  assign res.byte_index = idx;
  assign res.rx_byte    = rxb;
  assign res.frame_done = frame_flag;
  assign res.analog_red = red_flag;
  assign res.busy_res   = (st_nxt.phase != PH_IDLE);

endmodule

// ===== hw/rtl/gamepad_poll_serial_master.sv =====
// Game-pad serial poll master, driven by timing ticks.
// Input channel (in_valid/in_ready/in_data): one beat per timing tick, carrying
// a frame start request and the sampled pad data line. A start while a frame
// runs is ignored.
// Result channel (out_valid/out_ready/out_data): exactly one beat per input
// beat, giving the select, clock and command data levels after that tick,
// plus received-byte and frame-end events.
// Result: registered when its input beat is taken, so it appears in the cycle after.
// Throughput: one tick per cycle while results drain; the tick update is a single registered pass
// through the step logic, and the result register lets the next tick be taken
// in the same cycle the previous result leaves.
// Stall: while a result waits and out_ready is low, in_ready drops and the
// state holds; nothing is lost or repeated.
// Config (cfg_we/cfg_idx/cfg_wdata): written with no handshake; write only
// while idle. Registers: half period, byte gap, poll address, poll command.
// Reset (synchronous, rst_n low): link idle, no result pending,
// registers back to 5, 16, 0x01, 0x42.
module gamepad_poll_serial_master #(
  parameter int unsigned FRAME_BYTES = gpsm_pkg::FRAME_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  gpsm_pkg::in_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output gpsm_pkg::out_t           out_data,
  input  logic                     cfg_we,
  input  gpsm_pkg::cfg_idx_t       cfg_idx,
  input  logic [gpsm_pkg::CFG_W-1:0] cfg_wdata
);
  import gpsm_pkg::*;

  cfg_t   cfg_r;
  state_t state_r;
  state_t state_nxt;
  out_t   out_data_r;
  out_t   res;
  logic   out_valid_r;
  logic   take;

  // output register frees up when empty or draining this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  gpsm_step #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_step (
    .st     (state_r),
    .cfg    (cfg_r),
    .item   (in_data),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period_ticks <= HALF_RST;
      cfg_r.byte_gap_ticks    <= GAP_RST;
      cfg_r.poll_address      <= ADDR_RST;
      cfg_r.poll_command      <= CMD_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HALF: cfg_r.half_period_ticks <= cfg_wdata[HALF_W-1:0];
        REG_GAP:  cfg_r.byte_gap_ticks    <= cfg_wdata[GAP_W-1:0];
        REG_ADDR: cfg_r.poll_address      <= cfg_wdata[BYTE_W-1:0];
        REG_CMD:  cfg_r.poll_command      <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // link state advances once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase      <= PH_IDLE;
      state_r.bit_count  <= '0;
      state_r.byte_count <= '0;
      state_r.tick_count <= '0;
      state_r.tx_shift   <= '0;
      state_r.rx_shift   <= '0;
      state_r.id_byte    <= '0;
    end else if (take) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== dv/tb_gamepad_poll_serial_master.sv =====
module tb_gamepad_poll_serial_master;
  import gpsm_pkg::*;

  localparam int unsigned NBYTES      = FRAME_BYTES_DEF;
  localparam int unsigned N_CASES     = 10;
  localparam int unsigned RAND_TICKS  = 450;  // live ticks in the random part
  localparam int unsigned PHASE_TICKS = 150;  // live ticks per random settings phase
  localparam int unsigned MAX_PRINT   = 40;   // mismatch lines shown before going quiet

  // ---------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known level.
  // ---------------------------------------------------------------------------
  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_t              in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_we    = 1'b0;
  cfg_idx_t         cfg_idx   = REG_HALF;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #1 clk = ~clk;

  gamepad_poll_serial_master #(.FRAME_BYTES(NBYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the poll master: register copies and link state, reset values.
  // ---------------------------------------------------------------------------
  logic [HALF_W-1:0] m_half  = HALF_RST;
  logic [GAP_W-1:0]  m_gap   = GAP_RST;
  logic [BYTE_W-1:0] m_addr  = ADDR_RST;
  logic [BYTE_W-1:0] m_cmd   = CMD_RST;

  phase_t            m_phase = PH_IDLE;
  logic [BIT_W-1:0]  m_bit   = '0;
  logic [CNT_W-1:0]  m_byte  = '0;
  logic [TICK_W-1:0] m_tick  = '0;
  logic [BYTE_W-1:0] m_tx    = '0;
  logic [BYTE_W-1:0] m_rx    = '0;
  logic [BYTE_W-1:0] m_id    = '0;

  out_t              tick_exp_q [$];      // expected result beats, oldest first
  logic [BYTE_W-1:0] pad_resp [0:15];     // what the emulated pad answers per byte
  bit                quiet = 1'b0;        // no idling on either side while set

  int unsigned n_bad = 0, n_checked = 0, n_frames = 0, n_analog = 0, n_bytes = 0;
  int unsigned n_live_ticks = 0;          // ticks that start or advance a frame

  // directed cases: optional register set, first tick, then run the frame out
  typedef struct {
    bit          set_cfg;
    cfg_t        cfg;
    logic        start;
    logic        din;
    bit          run_out;
    logic [7:0]  pad_id;   // pad's answer in byte 1
    logic        fill;     // level the pad holds in every other byte
    bit          typed;    // first tick checked against want, not the mirror
    out_t        want;
  } dir_row_t;

  dir_row_t case_tab [N_CASES];

  // Byte boundary: next byte, or frame end once all bytes are through.
  function automatic void next_byte(output logic fr, output logic red);
    m_byte = m_byte + 1'b1;
    m_tick = '0;
    m_bit  = '0;
    m_rx   = '0;
    fr     = 1'b0;
    red    = 1'b0;
    if (m_byte >= NBYTES) begin
      m_phase = PH_IDLE;
      m_byte  = '0;
      fr      = 1'b1;
      red     = (m_id == ANALOG_ID);
    end else begin
      m_tx    = (m_byte == 4'd1) ? m_cmd : '0;
      m_phase = PH_HIGH;
    end
  endfunction

  // One timing tick through the mirror; returns the levels after the update.
  function automatic out_t poll_step(input in_t t);
    out_t        r;
    int unsigned hp;
    logic        fr, red;
    r   = '0;
    fr  = 1'b0;
    red = 1'b0;
    hp  = (m_half == '0) ? 1 : m_half;  // zero half period acts as one tick
    case (m_phase)
      PH_IDLE: begin
        if (t.start_req) begin
          m_phase = PH_HIGH;
          m_bit   = '0;
          m_byte  = '0;
          m_tick  = '0;
          m_tx    = m_addr;
          m_rx    = '0;
          m_id    = '0;
        end
      end
      PH_HIGH: begin
        if (m_tick + 32'd1 >= hp) begin
          m_phase = PH_LOW;
          m_tick  = '0;
        end else begin
          m_tick = m_tick + 1'b1;
        end
      end
      PH_LOW: begin
        if (m_tick + 32'd1 >= hp) begin
          // clock rises: sample din into the top, LSB first
          m_rx   = {t.din, m_rx[7:1]};
          m_tick = '0;
          if (m_bit == 3'd7) begin
            r.byte_done  = 1'b1;
            r.byte_index = m_byte;
            r.rx_byte    = m_rx;
            if (m_byte == 4'd1) m_id = m_rx;
            m_bit = '0;
            if (m_gap != '0) m_phase = PH_GAP;
            else next_byte(fr, red);
          end else begin
            m_bit   = m_bit + 1'b1;
            m_tx    = m_tx >> 1;
            m_phase = PH_HIGH;
          end
        end else begin
          m_tick = m_tick + 1'b1;
        end
      end
      default: begin
        if (m_tick + 32'd1 >= m_gap) next_byte(fr, red);
        else m_tick = m_tick + 1'b1;
      end
    endcase
    r.select_n   = (m_phase == PH_IDLE);
    r.clk_out    = (m_phase != PH_LOW);
    r.dout       = (m_phase == PH_HIGH || m_phase == PH_LOW) ? m_tx[0] : 1'b0;
    r.frame_done = fr;
    r.analog_red = red;
    r.busy_res   = (m_phase != PH_IDLE);
    return r;
  endfunction

  // Plain line levels with no byte or frame event.
  function automatic out_t lvl(input bit sel, input bit sck, input bit dat, input bit busy);
    out_t r;
    r          = '0;
    r.select_n = sel;
    r.clk_out  = sck;
    r.dout     = dat;
    r.busy_res = busy;
    return r;
  endfunction

  function automatic dir_row_t row(input bit set, input int unsigned h, g, a, cm,
                                   input bit st, dn, run, input int unsigned pid,
                                   input bit fill, typed, input out_t want);
    dir_row_t r;
    r.set_cfg               = set;
    r.cfg.half_period_ticks = h[HALF_W-1:0];
    r.cfg.byte_gap_ticks    = g[GAP_W-1:0];
    r.cfg.poll_address      = a[BYTE_W-1:0];
    r.cfg.poll_command      = cm[BYTE_W-1:0];
    r.start                 = st;
    r.din                   = dn;
    r.run_out               = run;
    r.pad_id                = pid[7:0];
    r.fill                  = fill;
    r.typed                 = typed;
    r.want                  = want;
    return r;
  endfunction

  task automatic flag(input string what, input int unsigned got, input int unsigned want);
    if (n_bad < MAX_PRINT)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    n_bad++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side. A beat may be preceded by a random idle gap; valid then stays
  // up with the payload fixed until in_ready is seen. in_ready is sampled on
  // the falling edge so the rising edge that takes the beat is known without
  // racing the block's own registers. The mirror steps once the beat is in.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input in_t d, input bit typed, input out_t want);
    out_t pred;
    bit   ok;
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!quiet && $urandom_range(0, 99) < 11);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    if (d.start_req || m_phase != PH_IDLE) n_live_ticks++;
    pred = poll_step(d);
    tick_exp_q.push_back(typed ? want : pred);
  endtask

  // Tick until the frame closes. The pad answers from pad_resp, with optional
  // noise on din, and stray start requests land while busy (must be ignored).
  task automatic finish_frame(input int unsigned noise_pct);
    in_t d;
    while (m_phase != PH_IDLE) begin
      d.start_req = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 99) < noise_pct) d.din = 1'($urandom_range(0, 1));
      else d.din = pad_resp[m_byte][m_bit];
      send_tick(d, 1'b0, '0);
    end
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Registers only change once every result beat is home and the result register
  // has settled. The link may be mid-frame: a new limit
  // then applies from the next tick.
  task automatic write_cfg(input cfg_t c);
    in_valid <= 1'b0;
    while (tick_exp_q.size() != 0) @(posedge clk);
    @(posedge clk);
    put_reg(REG_HALF, CFG_W'(c.half_period_ticks));
    put_reg(REG_GAP,  CFG_W'(c.byte_gap_ticks));
    put_reg(REG_ADDR, CFG_W'(c.poll_address));
    put_reg(REG_CMD,  CFG_W'(c.poll_command));
    cfg_we <= 1'b0;
    m_half = c.half_period_ticks;
    m_gap  = c.byte_gap_ticks;
    m_addr = c.poll_address;
    m_cmd  = c.poll_command;
  endtask

  // ---------------------------------------------------------------------------
  // Result side. out_ready toggles at random (none while quiet). A beat is
  // captured on the falling edge and checked on the following rising edge.
  // ---------------------------------------------------------------------------
  bit   res_take = 1'b0;
  out_t res_got;

  task automatic check_tick(input out_t got);
    out_t want;
    if (tick_exp_q.size() == 0) begin
      flag("result beat with nothing expected", got, 0);
    end else begin
      want = tick_exp_q.pop_front();
      if (got.select_n   !== want.select_n)   flag("select_n",   got.select_n,   want.select_n);
      if (got.clk_out    !== want.clk_out)    flag("clk_out",    got.clk_out,    want.clk_out);
      if (got.dout       !== want.dout)       flag("dout",       got.dout,       want.dout);
      if (got.byte_done  !== want.byte_done)  flag("byte_done",  got.byte_done,  want.byte_done);
      if (got.byte_index !== want.byte_index) flag("byte_index", got.byte_index, want.byte_index);
      if (got.rx_byte    !== want.rx_byte)    flag("rx_byte",    got.rx_byte,    want.rx_byte);
      if (got.frame_done !== want.frame_done) flag("frame_done", got.frame_done, want.frame_done);
      if (got.analog_red !== want.analog_red) flag("analog_red", got.analog_red, want.analog_red);
      if (got.busy_res   !== want.busy_res)   flag("busy_res",   got.busy_res,   want.busy_res);
      n_checked++;
      if (got.byte_done) n_bytes++;
      if (got.frame_done) n_frames++;
      if (got.frame_done && got.analog_red) n_analog++;
    end
  endtask

  always @(negedge clk) begin
    res_take = rst_n && out_valid && out_ready;
    res_got  = out_data;
  end

  always @(posedge clk) begin
    if (res_take) check_tick(res_got);
    out_ready <= quiet || ($urandom_range(0, 99) >= 11);
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed cases, then random settings phases, then drain.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    in_t         d;
    cfg_t        c;
    int unsigned k, b, ph, mark, rand_base;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // idle ticks after reset, then a frame start with reset settings
    case_tab[0] = row(0, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0, 1, lvl(1, 1, 0, 0));
    case_tab[1] = row(0, 0, 0, 0, 0, 0, 1, 0, 8'h00, 0, 1, lvl(1, 1, 0, 0));
    case_tab[2] = row(0, 0, 0, 0, 0, 1, 0, 0, 8'h00, 0, 1, lvl(0, 1, ADDR_RST[0], 1));
    // start while busy is ignored; clock still high, one tick counted
    case_tab[3] = row(0, 0, 0, 0, 0, 1, 1, 0, 8'h00, 0, 1, lvl(0, 1, ADDR_RST[0], 1));
    // half period cut mid-frame below the count: clock falls at once; zero gap,
    // so the last byte and the frame end share a tick; analog pad
    case_tab[4] = row(1, 1, 0, ADDR_RST, CMD_RST, 0, 0, 1, ANALOG_ID, 1, 1,
                      lvl(0, 0, ADDR_RST[0], 1));
    // zero half period and zero gap, restart on the tick after the frame end
    case_tab[5] = row(1, 0, 0, 8'hFF, 8'h00, 1, 1, 1, 8'h00, 0, 1, lvl(0, 1, 1, 1));
    // widest half period and gap, then cut back mid-frame and run out
    case_tab[6] = row(1, 1023, 4095, 8'hA5, 8'h5A, 1, 0, 0, 8'h5A, 0, 0, '0);
    case_tab[7] = row(0, 0, 0, 0, 0, 0, 1, 0, 8'h5A, 0, 1, lvl(0, 1, 1, 1));
    case_tab[8] = row(1, 0, 1, 8'hA5, 8'h5A, 0, 0, 1, 8'h5A, 1, 1, lvl(0, 0, 1, 1));
    // back to reset values, link idle
    case_tab[9] = row(1, HALF_RST, GAP_RST, ADDR_RST, CMD_RST, 0, 0, 0, 8'h00, 0, 1,
                      lvl(1, 1, 0, 0));

    for (k = 0; k < N_CASES; k++) begin
      if (case_tab[k].set_cfg) write_cfg(case_tab[k].cfg);
      for (b = 0; b < 16; b++) pad_resp[b] = {8{case_tab[k].fill}};
      pad_resp[1] = case_tab[k].pad_id;
      d.start_req = case_tab[k].start;
      d.din       = case_tab[k].din;
      send_tick(d, case_tab[k].typed, case_tab[k].want);
      if (case_tab[k].run_out) finish_frame(0);
    end

    // Random phases: mostly short bit times so many frames fit, the pad
    // answering properly with some din noise and stray starts mixed in.
    rand_base = n_live_ticks;
    for (ph = 0; n_live_ticks - rand_base < RAND_TICKS; ph++) begin
      quiet = (ph == 0);
      c.half_period_ticks = HALF_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 5)
                                                                : $urandom_range(0, 3));
      c.byte_gap_ticks    = GAP_W'(($urandom_range(0, 9) == 0) ? $urandom_range(4, 8)
                                                               : $urandom_range(0, 3));
      c.poll_address      = BYTE_W'($urandom);
      c.poll_command      = BYTE_W'($urandom);
      write_cfg(c);
      mark = n_live_ticks;
      while (n_live_ticks - mark < PHASE_TICKS) begin
        if (m_phase == PH_IDLE) begin
          for (b = 0; b < 16; b++) pad_resp[b] = BYTE_W'($urandom);
          if ($urandom_range(0, 1)) pad_resp[1] = ANALOG_ID;
          d.start_req = ($urandom_range(0, 3) == 0);
          d.din       = 1'($urandom_range(0, 1));
        end else begin
          d.start_req = ($urandom_range(0, 7) == 0);
          if ($urandom_range(0, 99) < 15) d.din = 1'($urandom_range(0, 1));
          else d.din = pad_resp[m_byte][m_bit];
        end
        send_tick(d, 1'b0, '0);
      end
      finish_frame(15);
    end
    quiet = 1'b0;

    // drain: every expected beat home, then a short wait for strays
    in_valid <= 1'b0;
    k = 0;
    while (tick_exp_q.size() != 0 && k < 100000) begin
      @(posedge clk);
      k++;
    end
    repeat (4) @(posedge clk);
    if (tick_exp_q.size() != 0) flag("result beats never delivered", tick_exp_q.size(), 0);

    $display("checked %0d result beats: %0d poll frames (%0d analog), %0d bytes received",
             n_checked, n_frames, n_analog, n_bytes);
    $display("%0d directed cases, %0d random settings phases, half 0..1023, gap 0..4095",
             N_CASES, ph);
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard, several times the slowest expected run
  initial begin : watchdog
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/gpsm_pkg.sv
hw/rtl/gpsm_step.sv
hw/rtl/gamepad_poll_serial_master.sv
dv/tb_gamepad_poll_serial_master.sv
